@@ rtl/dvmg_pkg.sv @@
// Shared types, constants and helpers for the dewarp vertex map generator.
// No dependencies; used by every module of the block.
package dvmg_pkg;

  localparam int BLOCK_SIZE_DEF = 16;
  localparam int IDX_W          = 9;
  localparam int Q_W            = 25;   // signed Q16.8
  localparam int SAT_W          = 50;
  localparam int CFG_W          = 32;
  localparam int REG_IDX_W      = 3;

  localparam logic signed [SAT_W-1:0] QMAX = SAT_W'(16777215);
  localparam logic signed [SAT_W-1:0] QMIN = -SAT_W'(16777216);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_OUT_DIMS    = 3'd0,
    REG_OUT_OFFSET  = 3'd1,
    REG_INV_SCALE_X = 3'd2,
    REG_INV_SCALE_Y = 3'd3,
    REG_ROTATION    = 3'd4,
    REG_CROP_DIMS   = 3'd5,
    REG_CROP_ORIGIN = 3'd6,
    REG_FLIP_FLAGS  = 3'd7
  } reg_index_t;

  typedef logic signed [Q_W-1:0] q_t;

  typedef struct packed {
    logic [15:0]        out_h;
    logic [15:0]        out_w;
    logic signed [15:0] off_y;
    logic signed [15:0] off_x;
    logic [23:0]        inv_x;
    logic [23:0]        inv_y;
    logic signed [15:0] sin_a;
    logic signed [15:0] cos_a;
    logic [15:0]        crop_h;
    logic [15:0]        crop_w;
    logic [15:0]        org_y;
    logic [15:0]        org_x;
    logic               transpose;
    logic               vflip;
    logic               hflip;
  } cfg_t;

  function automatic q_t sat_q(input logic signed [SAT_W-1:0] v);
    q_t r;
    if (v > QMAX) begin
      r = q_t'(QMAX);
    end else if (v < QMIN) begin
      r = q_t'(QMIN);
    end else begin
      r = q_t'(v);
    end
    return r;
  endfunction

endpackage

@@ rtl/dvmg_front.sv @@
// Front end: corner clamp, centring with offset, then inverse scale.
// Two register stages. Depends on dvmg_pkg.
module dvmg_front #(
  parameter int BLOCK_SIZE = dvmg_pkg::BLOCK_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dvmg_pkg::cfg_t             cfg,
  input  logic                       v_in,
  output logic                       ready_up,
  input  logic [dvmg_pkg::IDX_W-1:0] col,
  input  logic [dvmg_pkg::IDX_W-1:0] row,
  output logic                       v_out,
  input  logic                       ready_dn,
  output dvmg_pkg::q_t               x_out,
  output dvmg_pkg::q_t               y_out
);
  import dvmg_pkg::*;

  localparam int CXW  = IDX_W + $clog2(BLOCK_SIZE);
  localparam int CMPW = (CXW > 16) ? CXW : 16;

  logic va, vb;
  logic ready_a, ready_b;
  q_t   xa, ya;
  q_t   xa_next, ya_next, xb_next, yb_next;

  logic [CXW-1:0]    cx_raw, cy_raw;
  logic [15:0]       cx, cy;
  logic signed [26:0] xs, ys;
  logic signed [49:0] px, py;

  assign ready_b  = ~vb | ready_dn;
  assign ready_a  = ~va | ready_b;
  assign ready_up = ready_a;
  assign v_out    = vb;

  always_comb begin
    cx_raw = CXW'(col) * CXW'(BLOCK_SIZE);
    cy_raw = CXW'(row) * CXW'(BLOCK_SIZE);
    cx = (CMPW'(cx_raw) > CMPW'(cfg.out_w)) ? cfg.out_w : 16'(cx_raw);
    cy = (CMPW'(cy_raw) > CMPW'(cfg.out_h)) ? cfg.out_h : 16'(cy_raw);
    xs = $signed({3'b0, cx, 8'b0}) - $signed({4'b0, cfg.out_w, 7'b0}) + 27'sd128
       + $signed({{3{cfg.off_x[15]}}, cfg.off_x, 8'b0});
    ys = $signed({3'b0, cy, 8'b0}) - $signed({4'b0, cfg.out_h, 7'b0}) + 27'sd128
       + $signed({{3{cfg.off_y[15]}}, cfg.off_y, 8'b0});
    xa_next = sat_q(SAT_W'(xs));
    ya_next = sat_q(SAT_W'(ys));
  end

  // Q16.8 x Q8.16, round half up then floor back to Q16.8
  always_comb begin
    px = xa * $signed({1'b0, cfg.inv_x});
    py = ya * $signed({1'b0, cfg.inv_y});
    xb_next = sat_q((px + 50'sd32768) >>> 16);
    yb_next = sat_q((py + 50'sd32768) >>> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (ready_a) va <= v_in;
      if (ready_b) vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && v_in) begin
      xa <= xa_next;
      ya <= ya_next;
    end
    if (ready_b && va) begin
      x_out <= xb_next;
      y_out <= yb_next;
    end
  end

endmodule

@@ rtl/dvmg_rotate.sv @@
// Rotation by the configured cos/sin: products, then sum and rounding.
// Two register stages. Depends on dvmg_pkg.
module dvmg_rotate (
  input  logic           clk,
  input  logic           rst,
  input  dvmg_pkg::cfg_t cfg,
  input  logic           v_in,
  output logic           ready_up,
  input  dvmg_pkg::q_t   x_in,
  input  dvmg_pkg::q_t   y_in,
  output logic           v_out,
  input  logic           ready_dn,
  output dvmg_pkg::q_t   x_out,
  output dvmg_pkg::q_t   y_out
);
  import dvmg_pkg::*;

  logic va, vb;
  logic ready_a, ready_b;
  logic signed [40:0] pcx, psy, psx, pcy;
  logic signed [40:0] pcx_next, psy_next, psx_next, pcy_next;
  logic signed [41:0] sx, sy;
  q_t   xb_next, yb_next;

  assign ready_b  = ~vb | ready_dn;
  assign ready_a  = ~va | ready_b;
  assign ready_up = ready_a;
  assign v_out    = vb;

  always_comb begin
    pcx_next = cfg.cos_a * x_in;
    psy_next = cfg.sin_a * y_in;
    psx_next = cfg.sin_a * x_in;
    pcy_next = cfg.cos_a * y_in;
  end

  always_comb begin
    sx = 42'(pcx) - 42'(psy) + 42'sd8192;
    sy = 42'(psx) + 42'(pcy) + 42'sd8192;
    xb_next = sat_q(SAT_W'(sx >>> 14));
    yb_next = sat_q(SAT_W'(sy >>> 14));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (ready_a) va <= v_in;
      if (ready_b) vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && v_in) begin
      pcx <= pcx_next;
      psy <= psy_next;
      psx <= psx_next;
      pcy <= pcy_next;
    end
    if (ready_b && va) begin
      x_out <= xb_next;
      y_out <= yb_next;
    end
  end

endmodule

@@ rtl/dvmg_back.sv @@
// Back end: crop centre, flips, transpose, crop origin and Q12.4 output.
// Two register stages, the second being the output register. Depends on dvmg_pkg.
module dvmg_back (
  input  logic           clk,
  input  logic           rst,
  input  dvmg_pkg::cfg_t cfg,
  input  logic           v_in,
  output logic           ready_up,
  input  dvmg_pkg::q_t   x_in,
  input  dvmg_pkg::q_t   y_in,
  output logic           v_out,
  input  logic           ready_dn,
  output logic [15:0]    x_out,
  output logic [15:0]    y_out
);
  import dvmg_pkg::*;

  logic va, vb;
  logic ready_a, ready_b;
  q_t   xa, ya, xa_next, ya_next, xc, yc;
  q_t   xt, yt;
  logic signed [26:0] xcs, ycs, xfs, yfs, xo, yo;
  logic [15:0] xb_next, yb_next;

  function automatic logic [15:0] to_q12_4(input logic signed [26:0] v);
    logic [15:0] r;
    if (v <= 27'sd0) begin
      r = 16'd0;
    end else if (v[25:4] > 22'hffff) begin
      r = 16'hffff;
    end else begin
      r = v[19:4];
    end
    return r;
  endfunction

  assign ready_b  = ~vb | ready_dn;
  assign ready_a  = ~va | ready_b;
  assign ready_up = ready_a;
  assign v_out    = vb;

  always_comb begin
    xcs = 27'(x_in) + $signed({4'b0, cfg.crop_w, 7'b0}) - 27'sd128;
    ycs = 27'(y_in) + $signed({4'b0, cfg.crop_h, 7'b0}) - 27'sd128;
    xc  = sat_q(SAT_W'(xcs));
    yc  = sat_q(SAT_W'(ycs));
    xfs = $signed({3'b0, cfg.crop_w, 8'b0}) - 27'sd256 - 27'(xc);
    yfs = $signed({3'b0, cfg.crop_h, 8'b0}) - 27'sd256 - 27'(yc);
    xa_next = cfg.hflip ? sat_q(SAT_W'(xfs)) : xc;
    ya_next = cfg.vflip ? sat_q(SAT_W'(yfs)) : yc;
  end

  always_comb begin
    xt = cfg.transpose ? ya : xa;
    yt = cfg.transpose ? xa : ya;
    xo = 27'(xt) + $signed({3'b0, cfg.org_x, 8'b0});
    yo = 27'(yt) + $signed({3'b0, cfg.org_y, 8'b0});
    xb_next = to_q12_4(xo);
    yb_next = to_q12_4(yo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (ready_a) va <= v_in;
      if (ready_b) vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && v_in) begin
      xa <= xa_next;
      ya <= ya_next;
    end
    if (ready_b && va) begin
      x_out <= xb_next;
      y_out <= yb_next;
    end
  end

endmodule

@@ rtl/dewarp_vertex_map_generator.sv @@
// Top level of the dewarp vertex map generator: config registers and pipeline.
// Depends on dvmg_pkg, dvmg_front, dvmg_rotate and dvmg_back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------
//   input    | in_valid, in_stall | tile_col, tile_row
//   output   | out_valid, out_stall | src_x, src_y
//   config   | cfg_we             | cfg_index, cfg_data
//
// One item per cycle while out_stall is low; there is one register stage for each of
// centre, scale, rotate products, rotate sum, crop/flip and output.
// Synchronous reset empties the pipeline and restores register defaults.
// A stalled output holds its item; stages behind it keep filling bubbles,
// and in_stall rises only once every stage holds an item.
module dewarp_vertex_map_generator #(
  parameter int BLOCK_SIZE = dvmg_pkg::BLOCK_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dvmg_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [dvmg_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dvmg_pkg::IDX_W-1:0]     tile_col,
  input  logic [dvmg_pkg::IDX_W-1:0]     tile_row,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    src_x,
  output logic [15:0]                    src_y
);
  import dvmg_pkg::*;

  // unit scales, cos = 1.0, everything else zero
  localparam cfg_t CFG_RESET = {64'd0, 24'h010000, 24'h010000, 16'd0, 16'd16384,
                                64'd0, 3'd0};

  cfg_t cfg;
  logic f_ready, r_ready, b_ready;
  logic f_valid, r_valid;
  q_t   fx, fy, rx, ry;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_OUT_DIMS:    {cfg.out_h, cfg.out_w} <= cfg_data;
        REG_OUT_OFFSET:  {cfg.off_y, cfg.off_x} <= cfg_data;
        REG_INV_SCALE_X: cfg.inv_x <= cfg_data[23:0];
        REG_INV_SCALE_Y: cfg.inv_y <= cfg_data[23:0];
        REG_ROTATION:    {cfg.sin_a, cfg.cos_a} <= cfg_data;
        REG_CROP_DIMS:   {cfg.crop_h, cfg.crop_w} <= cfg_data;
        REG_CROP_ORIGIN: {cfg.org_y, cfg.org_x} <= cfg_data;
        REG_FLIP_FLAGS:  {cfg.transpose, cfg.vflip, cfg.hflip} <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign in_stall = ~f_ready;

  dvmg_front #(.BLOCK_SIZE(BLOCK_SIZE)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .v_in     (in_valid),
    .ready_up (f_ready),
    .col      (tile_col),
    .row      (tile_row),
    .v_out    (f_valid),
    .ready_dn (r_ready),
    .x_out    (fx),
    .y_out    (fy)
  );

  dvmg_rotate u_rotate (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .v_in     (f_valid),
    .ready_up (r_ready),
    .x_in     (fx),
    .y_in     (fy),
    .v_out    (r_valid),
    .ready_dn (b_ready),
    .x_out    (rx),
    .y_out    (ry)
  );

  dvmg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .v_in     (r_valid),
    .ready_up (b_ready),
    .x_in     (rx),
    .y_in     (ry),
    .v_out    (out_valid),
    .ready_dn (~out_stall),
    .x_out    (src_x),
    .y_out    (src_y)
  );

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && f_valid && r_valid))
    else $error("input stalled while the pipeline has room");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");

  a_bubble_moves: assert property (@(posedge clk) disable iff (rst)
    (!out_stall && r_valid) |-> ##2 out_valid)
    else $error("item lost between rotate and back end");

endmodule

@@ tb/tb_dewarp_vertex_map_generator.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for dewarp_vertex_map_generator: directed vertex table, then
// random configurations and vertices checked against a fixed-point source-position model.
// Depends on dvmg_pkg and the block's RTL only.
module tb_dewarp_vertex_map_generator;
  import dvmg_pkg::*;

  localparam int     CORNER_STEP  = BLOCK_SIZE_DEF;
  localparam longint Q16_8_MAX    = 64'sd16777215;
  localparam longint Q16_8_MIN    = -64'sd16777216;
  localparam int     DRAIN_PAUSE  = 12;
  localparam int     QUIET_LIMIT  = 2000;
  localparam int     ERR_PRINT    = 100;
  localparam int     CFGS_PER_PH  = 4;
  localparam int     ITEMS_PER_CF = 108;
  localparam int     FLIP_H       = 0;
  localparam int     FLIP_V       = 1;
  localparam int     FLIP_T       = 2;

  localparam logic [2:0] PRE_RESET   = 3'd0;
  localparam logic [2:0] PRE_IDENT   = 3'd1;
  localparam logic [2:0] PRE_OFFSET  = 3'd2;
  localparam logic [2:0] PRE_EXTREME = 3'd3;
  localparam logic [2:0] PRE_MIN     = 3'd4;
  localparam logic [2:0] PRE_ROT     = 3'd5;

  typedef struct packed {
    logic [15:0]        out_w;
    logic [15:0]        out_h;
    logic signed [15:0] off_x;
    logic signed [15:0] off_y;
    logic [23:0]        inv_x;
    logic [23:0]        inv_y;
    logic signed [15:0] cos_a;
    logic signed [15:0] sin_a;
    logic [15:0]        crop_w;
    logic [15:0]        crop_h;
    logic [15:0]        org_x;
    logic [15:0]        org_y;
    logic [2:0]         flips;
  } warp_cfg_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } src_pair_t;

  typedef struct packed {
    logic [2:0]  preset;
    logic [8:0]  col;
    logic [8:0]  row;
    logic        known;
    logic [15:0] ex;
    logic [15:0] ey;
  } dir_row_t;

  // known rows: reset map collapses to origin; identity map gives index * 256 in Q12.4
  localparam int DIR_N = 24;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{PRE_RESET,   9'd0,   9'd0,   1'b1, 16'd0,     16'd0},
    '{PRE_RESET,   9'd256, 9'd256, 1'b1, 16'd0,     16'd0},
    '{PRE_RESET,   9'd511, 9'd511, 1'b1, 16'd0,     16'd0},
    '{PRE_RESET,   9'd1,   9'd0,   1'b1, 16'd0,     16'd0},
    '{PRE_IDENT,   9'd0,   9'd0,   1'b1, 16'd0,     16'd0},
    '{PRE_IDENT,   9'd1,   9'd2,   1'b1, 16'd256,   16'd512},
    '{PRE_IDENT,   9'd255, 9'd255, 1'b1, 16'd65280, 16'd65280},
    '{PRE_IDENT,   9'd256, 9'd256, 1'b1, 16'hffff,  16'hffff},
    '{PRE_IDENT,   9'd511, 9'd0,   1'b1, 16'hffff,  16'd0},
    '{PRE_IDENT,   9'd0,   9'd511, 1'b1, 16'd0,     16'hffff},
    '{PRE_OFFSET,  9'd0,   9'd0,   1'b1, 16'd0,     16'd256},
    '{PRE_OFFSET,  9'd1,   9'd255, 1'b1, 16'd0,     16'hffff},
    '{PRE_OFFSET,  9'd2,   9'd0,   1'b1, 16'd256,   16'd256},
    '{PRE_EXTREME, 9'd0,   9'd0,   1'b0, 16'd0,     16'd0},
    '{PRE_EXTREME, 9'd511, 9'd511, 1'b0, 16'd0,     16'd0},
    '{PRE_EXTREME, 9'd170, 9'd341, 1'b0, 16'd0,     16'd0},
    '{PRE_MIN,     9'd0,   9'd0,   1'b0, 16'd0,     16'd0},
    '{PRE_MIN,     9'd511, 9'd511, 1'b0, 16'd0,     16'd0},
    '{PRE_MIN,     9'd85,  9'd170, 1'b0, 16'd0,     16'd0},
    '{PRE_ROT,     9'd0,   9'd0,   1'b0, 16'd0,     16'd0},
    '{PRE_ROT,     9'd40,  9'd30,  1'b0, 16'd0,     16'd0},
    '{PRE_ROT,     9'd20,  9'd15,  1'b0, 16'd0,     16'd0},
    '{PRE_ROT,     9'd511, 9'd3,   1'b0, 16'd0,     16'd0},
    '{PRE_ROT,     9'd7,   9'd0,   1'b0, 16'd0,     16'd0}
  };

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [IDX_W-1:0]     tile_col  = '0;
  logic [IDX_W-1:0]     tile_row  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [15:0]          src_x;
  logic [15:0]          src_y;

  logic        typed_known = 1'b0;
  src_pair_t   typed_src   = '0;
  warp_cfg_t   cur_cfg;
  src_pair_t   expected_src [$];
  int          err_count     = 0;
  int          quiet_cycles  = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;

  dewarp_vertex_map_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .tile_col  (tile_col),
    .tile_row  (tile_row),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .src_x     (src_x),
    .src_y     (src_y)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_q(input longint v);
    if (v > Q16_8_MAX) begin
      return Q16_8_MAX;
    end
    if (v < Q16_8_MIN) begin
      return Q16_8_MIN;
    end
    return v;
  endfunction

  function automatic logic [15:0] to_fix12_4(input longint v);
    if (v <= 0) begin
      return 16'd0;
    end
    if ((v >>> 4) > 65535) begin
      return 16'hffff;
    end
    return 16'(v >>> 4);
  endfunction

  function automatic src_pair_t map_vertex(input warp_cfg_t c, input logic [8:0] col,
                                           input logic [8:0] row);
    longint ow, oh, cw, ch, ca, sa, px, py, rx, ry, t;
    src_pair_t r;
    ow = longint'(c.out_w);
    oh = longint'(c.out_h);
    cw = longint'(c.crop_w);
    ch = longint'(c.crop_h);
    ca = longint'($signed(c.cos_a));
    sa = longint'($signed(c.sin_a));
    px = longint'(col) * CORNER_STEP;
    py = longint'(row) * CORNER_STEP;
    if (px > ow) px = ow;
    if (py > oh) py = oh;
    px = clamp_q(px * 256 - (ow * 128 - 128) + longint'($signed(c.off_x)) * 256);
    py = clamp_q(py * 256 - (oh * 128 - 128) + longint'($signed(c.off_y)) * 256);
    px = clamp_q((px * longint'(c.inv_x) + 32768) >>> 16);
    py = clamp_q((py * longint'(c.inv_y) + 32768) >>> 16);
    rx = clamp_q((ca * px - sa * py + 8192) >>> 14);
    ry = clamp_q((sa * px + ca * py + 8192) >>> 14);
    px = clamp_q(rx + cw * 128 - 128);
    py = clamp_q(ry + ch * 128 - 128);
    if (c.flips[FLIP_H]) px = clamp_q((cw - 1) * 256 - px);
    if (c.flips[FLIP_V]) py = clamp_q((ch - 1) * 256 - py);
    if (c.flips[FLIP_T]) begin
      t  = px;
      px = py;
      py = t;
    end
    px = px + longint'(c.org_x) * 256;
    py = py + longint'(c.org_y) * 256;
    r.x = to_fix12_4(px);
    r.y = to_fix12_4(py);
    return r;
  endfunction

  function automatic warp_cfg_t preset_cfg(input logic [2:0] p);
    warp_cfg_t c;
    c       = '0;
    c.inv_x = 24'h010000;
    c.inv_y = 24'h010000;
    c.cos_a = 16'sd16384;
    case (p)
      PRE_IDENT, PRE_OFFSET: begin
        c.out_w  = 16'd4096;
        c.out_h  = 16'd4096;
        c.crop_w = 16'd4096;
        c.crop_h = 16'd4096;
        if (p == PRE_OFFSET) begin
          c.off_x = -16'sd16;
          c.off_y = 16'sd16;
        end
      end
      PRE_EXTREME: begin
        c.out_w  = '1;
        c.out_h  = '1;
        c.off_x  = 16'sh7fff;
        c.off_y  = 16'sh7fff;
        c.inv_x  = '1;
        c.inv_y  = '1;
        c.cos_a  = 16'sh8000;
        c.sin_a  = 16'sh7fff;
        c.crop_w = '1;
        c.crop_h = '1;
        c.org_x  = '1;
        c.org_y  = '1;
        c.flips  = 3'b111;
      end
      PRE_MIN: begin
        // zero crop size, zero scale, most negative offsets
        c.out_w = 16'd1000;
        c.out_h = 16'd700;
        c.off_x = 16'sh8000;
        c.off_y = 16'sh8000;
        c.inv_x = '0;
        c.inv_y = '0;
        c.cos_a = 16'sh7fff;
        c.sin_a = 16'sh8000;
        c.flips = 3'b011;
      end
      PRE_ROT: begin
        c.out_w  = 16'd640;
        c.out_h  = 16'd480;
        c.off_x  = 16'sd3;
        c.off_y  = -16'sd5;
        c.inv_x  = 24'h008000;
        c.inv_y  = 24'h020000;
        c.cos_a  = 16'sd0;
        c.sin_a  = 16'sd16384;
        c.crop_w = 16'd1920;
        c.crop_h = 16'd1080;
        c.org_x  = 16'd100;
        c.org_y  = 16'd50;
        c.flips  = 3'b100;
      end
      default: begin
      end
    endcase
    return c;
  endfunction

  function automatic warp_cfg_t rand_cfg();
    warp_cfg_t c;
    real ang;
    c.out_w  = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(0, 4096));
    c.out_h  = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(0, 4096));
    c.off_x  = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(0, 200) - 100);
    c.off_y  = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(0, 200) - 100);
    c.inv_x  = ($urandom_range(99) < 10) ? 24'($urandom) : 24'($urandom_range(16384, 262144));
    c.inv_y  = ($urandom_range(99) < 10) ? 24'($urandom) : 24'($urandom_range(16384, 262144));
    if ($urandom_range(99) < 15) begin
      {c.sin_a, c.cos_a} = $urandom;
    end else begin
      ang     = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
      c.cos_a = 16'($rtoi(16384.0 * $cos(ang)));
      c.sin_a = 16'($rtoi(16384.0 * $sin(ang)));
    end
    c.crop_w = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(0, 4096));
    c.crop_h = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(0, 4096));
    c.org_x  = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(0, 2048));
    c.org_y  = ($urandom_range(99) < 10) ? 16'($urandom) : 16'($urandom_range(0, 2048));
    c.flips  = 3'($urandom_range(0, 7));
    return c;
  endfunction

  task automatic report(input string msg);
    if (err_count < ERR_PRINT) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    err_count++;
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // upper bits of the narrow registers carry junk; the block must ignore them
  task automatic program_cfg(input warp_cfg_t c);
    write_reg(REG_OUT_DIMS,    {c.out_h, c.out_w});
    write_reg(REG_OUT_OFFSET,  {c.off_y, c.off_x});
    write_reg(REG_INV_SCALE_X, {8'($urandom), c.inv_x});
    write_reg(REG_INV_SCALE_Y, {8'($urandom), c.inv_y});
    write_reg(REG_ROTATION,    {c.sin_a, c.cos_a});
    write_reg(REG_CROP_DIMS,   {c.crop_h, c.crop_w});
    write_reg(REG_CROP_ORIGIN, {c.org_y, c.org_x});
    write_reg(REG_FLIP_FLAGS,  {29'($urandom), c.flips});
    cfg_we  <= 1'b0;
    cur_cfg  = c;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_src.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_vertex(input logic [8:0] c, input logic [8:0] r, input logic known,
                             input src_pair_t typed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    tile_col    <= c;
    tile_row    <= r;
    typed_known <= known;
    typed_src   <= typed;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : scoreboard
    src_pair_t want;
    if (!rst && in_valid && !in_stall) begin
      want = typed_known ? typed_src : map_vertex(cur_cfg, tile_col, tile_row);
      expected_src = {expected_src, want};
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_src.size() == 0) begin
        report($sformatf("unexpected item src_x=%0d src_y=%0d", src_x, src_y));
      end else begin
        want = expected_src.pop_front();
        if (src_x !== want.x) report($sformatf("src_x %0d, want %0d", src_x, want.x));
        if (src_y !== want.y) report($sformatf("src_y %0d, want %0d", src_y, want.y));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    logic [2:0]  cur_preset;
    int          span;
    logic [8:0]  c, r;
    cur_cfg    = preset_cfg(PRE_RESET);
    cur_preset = PRE_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 9;
    stall_pct     = 53;
    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_ROWS[i].preset != cur_preset) begin
        settle();
        cur_preset = DIR_ROWS[i].preset;
        program_cfg(preset_cfg(cur_preset));
      end
      send_vertex(DIR_ROWS[i].col, DIR_ROWS[i].row, DIR_ROWS[i].known,
                  '{x: DIR_ROWS[i].ex, y: DIR_ROWS[i].ey});
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 53 : 0;
      stall_pct     = (ph == 0) ? 53 : (ph == 1) ? 9 : 0;
      for (int k = 0; k < CFGS_PER_PH; k++) begin
        settle();
        program_cfg(rand_cfg());
        for (int n = 0; n < ITEMS_PER_CF; n++) begin
          span = int'(cur_cfg.out_w) / CORNER_STEP + 1;
          if (span > 511) span = 511;
          c = ($urandom_range(99) < 80) ? 9'($urandom_range(0, span)) : 9'($urandom_range(0, 511));
          span = int'(cur_cfg.out_h) / CORNER_STEP + 1;
          if (span > 511) span = 511;
          r = ($urandom_range(99) < 80) ? 9'($urandom_range(0, span)) : 9'($urandom_range(0, 511));
          send_vertex(c, r, 1'b0, '0);
        end
      end
    end

    settle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/dvmg_pkg.sv
rtl/dvmg_front.sv
rtl/dvmg_rotate.sv
rtl/dvmg_back.sv
rtl/dewarp_vertex_map_generator.sv
tb/tb_dewarp_vertex_map_generator.sv
